@@ src/siq_pkg.sv @@
// ----------------------------------------------------------------------------
// siq_pkg
// Shared types, sizes and helpers for the sorted-list priority queue.
// ----------------------------------------------------------------------------
package siq_pkg;

   // Sizes
   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 10;
   localparam int TAG_BITS      = 16;
   localparam int ADDR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS      = COUNT_BITS + 1;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Status codes carried in each result word
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } siq_status_type;

   // One stored queue entry
   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [TAG_BITS-1:0]      tag;
   } siq_entry_type;

   // One result word
   typedef struct packed {
      siq_status_type           status;
      siq_entry_type            popped;
      logic                     head_valid;
      siq_entry_type            head;
      logic [COUNT_BITS-1:0]    entry_count;
   } siq_result_type;

   // Physical slot of a list position, with the head at base (ring buffer).
   // base + offs stays below twice the depth, so one subtract wraps it.
   function automatic logic [ADDR_BITS-1:0] slot_addr(
      input logic [ADDR_BITS-1:0]  base,
      input logic [COUNT_BITS-1:0] offs
   );
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(base) + SUM_BITS'(offs);
      if (sum >= SUM_BITS'(QUEUE_DEPTH)) begin
         sum = sum - SUM_BITS'(QUEUE_DEPTH);
      end
      return sum[ADDR_BITS-1:0];
   endfunction

endpackage

@@ src/siq_if.sv @@
// ----------------------------------------------------------------------------
// siq_req_if / siq_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface siq_req_if import siq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [PRIORITY_BITS-1:0] new_priority;
   logic [TAG_BITS-1:0]      new_tag;

   modport source (output valid, output op, output new_priority, output new_tag,
                   input ready);
   modport sink   (input valid, input op, input new_priority, input new_tag,
                   output ready);
endinterface

interface siq_rsp_if import siq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [PRIORITY_BITS-1:0] popped_priority;
   logic [TAG_BITS-1:0]      popped_tag;
   logic                     head_valid;
   logic [PRIORITY_BITS-1:0] head_priority;
   logic [TAG_BITS-1:0]      head_tag;
   logic [COUNT_BITS-1:0]    entry_count;

   modport source (output valid, output status, output popped_priority,
                   output popped_tag, output head_valid, output head_priority,
                   output head_tag, output entry_count, input ready);
   modport sink   (input valid, input status, input popped_priority,
                   input popped_tag, input head_valid, input head_priority,
                   input head_tag, input entry_count, output ready);
endinterface

@@ src/siq_engine.sv @@
// ----------------------------------------------------------------------------
// siq_engine
// Sequencer and slot memory. The list sits in a ring buffer; a pop moves the
// head pointer, a push walks back from the tail moving entries up one slot.
// ----------------------------------------------------------------------------
module siq_engine import siq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   siq_req_if.sink        req_ch,
   input  logic           out_free,
   output logic           done,
   output siq_result_type result
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUT_HEAD,
      ST_POP_LOAD,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_BITS-1:0]   head_ptr_ff, head_ptr_in;
   logic [COUNT_BITS-1:0]  fill_ff, fill_in;
   logic [COUNT_BITS-1:0]  k_ff, k_in;
   siq_entry_type          head_ff, head_in;
   siq_entry_type          new_ff, new_in;
   siq_entry_type          popped_ff, popped_in;
   siq_status_type         status_ff, status_in;

   // Slot memory, one write and one registered read per cycle
   siq_entry_type          mem [QUEUE_DEPTH];
   siq_entry_type          rd_data_ff;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   siq_entry_type          wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Next-state and memory control
   always_comb begin
      state_in    = state_ff;
      head_ptr_in = head_ptr_ff;
      fill_in     = fill_ff;
      k_in        = k_ff;
      head_in     = head_ff;
      new_in      = new_ff;
      popped_in   = popped_ff;
      status_in   = status_ff;
      rd_addr     = head_ptr_ff;
      wr_en       = 1'b0;
      wr_addr     = slot_addr(head_ptr_ff, k_ff);
      wr_data     = new_ff;
      done        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               new_in    = '{prio: req_ch.new_priority, tag: req_ch.new_tag};
               popped_in = '0;
               status_in = STATUS_OK;
               if (req_ch.op == OP_POP) begin
                  if (fill_ff == '0) begin
                     status_in = STATUS_POP_EMPTY;
                     state_in  = ST_FINISH;
                  end else begin
                     // take the head, fetch the next one
                     popped_in   = head_ff;
                     head_ptr_in = slot_addr(head_ptr_ff, COUNT_BITS'(1));
                     fill_in     = fill_ff - COUNT_BITS'(1);
                     rd_addr     = slot_addr(head_ptr_ff, COUNT_BITS'(1));
                     state_in    = (fill_ff == COUNT_BITS'(1)) ? ST_FINISH : ST_POP_LOAD;
                  end
               end else begin
                  if (fill_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
                     status_in = STATUS_PUSH_FULL;
                     state_in  = ST_FINISH;
                  end else if (fill_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = head_ptr_ff;
                     wr_data  = new_in;
                     head_in  = new_in;
                     fill_in  = COUNT_BITS'(1);
                     state_in = ST_FINISH;
                  end else begin
                     // start the walk from the tail
                     fill_in  = fill_ff + COUNT_BITS'(1);
                     k_in     = fill_ff;
                     rd_addr  = slot_addr(head_ptr_ff, fill_ff - COUNT_BITS'(1));
                     state_in = ST_SHIFT;
                  end
               end
            end
         end

         ST_SHIFT: begin
            wr_en = 1'b1;
            if (k_ff == COUNT_BITS'(1)) begin
               // next to the head: decide on the cached head copy
               if (head_ff.prio > new_ff.prio) begin
                  wr_data  = head_ff;
                  state_in = ST_PUT_HEAD;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (rd_data_ff.prio >= new_ff.prio) begin
               // move entry k-1 up and read the one below it
               wr_data  = rd_data_ff;
               k_in     = k_ff - COUNT_BITS'(1);
               rd_addr  = slot_addr(head_ptr_ff, k_ff - COUNT_BITS'(2));
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_PUT_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = head_ptr_ff;
            head_in  = new_ff;
            state_in = ST_FINISH;
         end

         ST_POP_LOAD: begin
            head_in  = rd_data_ff;
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            done = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result word
   always_comb begin
      result.status      = status_ff;
      result.popped      = popped_ff;
      result.head_valid  = (fill_ff != '0);
      result.head        = (fill_ff != '0) ? head_ff : '0;
      result.entry_count = fill_ff;
   end

   // State and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ptr_ff <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         head_ptr_ff <= head_ptr_in;
         fill_ff     <= fill_in;
      end
      k_ff      <= k_in;
      head_ff   <= head_in;
      new_ff    <= new_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

endmodule

@@ src/sorted_insert_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_core
// Min-first priority queue of QUEUE_DEPTH entries held as a sorted list.
//
// req_ch carries one request word: op (push or pop), new_priority, new_tag.
// rsp_ch returns one result word per request: status, the popped entry, the
// head entry and the entry count after the operation.
// One request is worked on at a time. A pop with entries left over reads
// one slot for the new head. A push into an empty queue writes the head
// slot directly; otherwise it walks back from the tail, one entry moved
// up per cycle through the slot memory, until the new entry has its place.
// The next request is taken the cycle after the result enters the output
// register, so the output may hold a word while the next one is processed.
// Reset empties the queue at once; slot contents are not cleared.
// While the receiver stalls, the output register holds its word and the
// engine waits with the following result until that word is taken.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core import siq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   siq_req_if.sink    req_ch,
   siq_rsp_if.source  rsp_ch
);

   logic           done;
   logic           out_free;
   siq_result_type result;

   logic           rsp_valid_ff, rsp_valid_in;
   siq_result_type rsp_data_ff, rsp_data_in;

   siq_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .done     (done),
      .result   (result)
   );

   // Output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Drive the result channel
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_data_ff.status;
   assign rsp_ch.popped_priority = rsp_data_ff.popped.prio;
   assign rsp_ch.popped_tag      = rsp_data_ff.popped.tag;
   assign rsp_ch.head_valid      = rsp_data_ff.head_valid;
   assign rsp_ch.head_priority   = rsp_data_ff.head.prio;
   assign rsp_ch.head_tag        = rsp_data_ff.head.tag;
   assign rsp_ch.entry_count     = rsp_data_ff.entry_count;

endmodule
